[sv/sqi_pkg.sv]
package sqi_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_PROBS   = 4;
  localparam int PROB_REGS   = 4;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = 11;
  localparam int PROB_W      = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int PIDX_W      = 2;
  localparam int PCNT_W      = 3;
  localparam int PROB_LIMIT  = (MAX_PROBS < PROB_REGS) ? MAX_PROBS : PROB_REGS;

  localparam logic [PROB_W-1:0]    PROB_ONE       = 17'h10000;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_3     = 3'd4;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } sqi_in_t;

  typedef struct packed {
    logic signed [31:0]  quantile_value;
    logic [PIDX_W-1:0]   prob_index;
    logic [CNT_W-1:0]    sample_count;
    logic                overflow;
    logic                last_result;
  } sqi_out_t;

endpackage

[sv/sample_quantile_interpolated.sv]
// Sample quantile (type 7, linear interpolation). Samples are inserted in
// ascending order into a 1024-word store as they arrive. An accepted word is
// written directly when the store is empty; otherwise each stored sample
// greater than it is shifted up one place through the single read/write
// port pair of the store before the word is placed.
// After the word flagged last, each configured probability passes through
// a position multiply, two store reads, an interpolation multiply when it
// interpolates, and the output register; a stalled output holds it there.
// A new sample is taken once the final result is registered. Samples
// beyond 1024 are dropped and flagged in the results.
module sample_quantile_interpolated
  import sqi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sqi_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sqi_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [PROB_W-1:0]    cfg_wdata
);

  typedef enum logic [2:0] {
    IDLE, SHIFT, PLACE, Q_POS, Q_RDA, Q_RDB, Q_MUL, Q_EMIT
  } state_t;

  state_t state_r;

  logic signed [31:0] mem [MAX_SAMPLES];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic signed [31:0] mem_wd;
  logic [ADDR_W-1:0]  mem_ra;
  logic signed [31:0] rd_r;

  logic [PCNT_W-1:0]  prob_count_r;
  logic [PROB_W-1:0]  prob_r [PROB_REGS];

  logic [CNT_W-1:0]   cnt_r;
  logic               ovf_r;
  logic signed [31:0] v_r;
  logic               last_r;
  logic [ADDR_W-1:0]  idx_r;
  logic [PIDX_W-1:0]  qi_r;
  logic [27:0]        pos_r;
  logic [ADDR_W-1:0]  lo_r;
  logic               need_b_r;
  logic signed [31:0] a_r;
  logic [47:0]        prod_r;
  logic signed [31:0] res_r;
  logic               out_valid_r;
  sqi_out_t           out_r;

  logic               in_acc;
  logic               full;
  logic [PCNT_W-1:0]  ecnt;
  logic [PROB_W-1:0]  psat;
  logic [11:0]        lo_raw;
  logic [ADDR_W-1:0]  lo_c;
  logic [CNT_W-1:0]   lo_inc;
  logic [31:0]        diff;
  logic               out_free;
  logic               q_last;
  logic [ADDR_W-1:0]  cnt_m1;

  assign in_stall  = (state_r != IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign full      = (cnt_r >= CNT_W'(MAX_SAMPLES));
  assign cnt_m1    = ADDR_W'(cnt_r - 1'b1);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    if (prob_count_r == '0) begin
      ecnt = PCNT_W'(1);
    end else if (prob_count_r > PCNT_W'(PROB_LIMIT)) begin
      ecnt = PCNT_W'(PROB_LIMIT);
    end else begin
      ecnt = prob_count_r;
    end
  end

  assign q_last = ({1'b0, qi_r} == ecnt - 1'b1);
  assign psat   = prob_r[qi_r][PROB_W-1] ? PROB_ONE : prob_r[qi_r];
  assign lo_raw = pos_r[27:16];
  assign lo_c   = ({1'b0, lo_raw} >= {2'b0, cnt_r}) ? cnt_m1 : lo_raw[ADDR_W-1:0];
  assign lo_inc = CNT_W'({1'b0, lo_r}) + 1'b1;
  assign diff   = 32'(rd_r - a_r);

  // store port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = v_r;
    mem_ra = idx_r;
    unique case (state_r)
      IDLE: begin
        mem_ra = cnt_m1;
        if (in_acc && !full && cnt_r == '0) begin
          mem_we = 1'b1;
          mem_wa = '0;
          mem_wd = in_data.sample;
        end
      end
      SHIFT: begin
        mem_we = 1'b1;
        mem_wa = idx_r;
        mem_wd = (rd_r > v_r) ? rd_r : v_r;
        mem_ra = idx_r - ADDR_W'(2);
      end
      PLACE: begin
        mem_we = 1'b1;
        mem_wa = '0;
        mem_wd = v_r;
      end
      Q_RDA:   mem_ra = lo_c;
      Q_RDB:   mem_ra = ADDR_W'(lo_r + 1'b1);
      default: mem_ra = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prob_count_r <= 3'd2;
      prob_r[0]    <= 17'd1638;
      prob_r[1]    <= 17'd63898;
      prob_r[2]    <= 17'd32768;
      prob_r[3]    <= 17'd32768;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PROB_COUNT: prob_count_r <= cfg_wdata[PCNT_W-1:0];
        REG_PROB_0:     prob_r[0] <= cfg_wdata;
        REG_PROB_1:     prob_r[1] <= cfg_wdata;
        REG_PROB_2:     prob_r[2] <= cfg_wdata;
        REG_PROB_3:     prob_r[3] <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      qi_r        <= '0;
      last_r      <= 1'b0;
    end else begin
      if (state_r == Q_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_acc) begin
            v_r    <= in_data.sample;
            last_r <= in_data.last;
            idx_r  <= cnt_r[ADDR_W-1:0];
            qi_r   <= '0;
            if (full) begin
              ovf_r   <= 1'b1;
              state_r <= in_data.last ? Q_POS : IDLE;
            end else if (cnt_r == '0) begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= in_data.last ? Q_POS : IDLE;
            end else begin
              state_r <= SHIFT;
            end
          end
        end
        SHIFT: begin
          if (rd_r > v_r) begin
            idx_r <= idx_r - 1'b1;
            if (idx_r == ADDR_W'(1)) begin
              state_r <= PLACE;
            end
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= last_r ? Q_POS : IDLE;
          end
        end
        PLACE: begin
          cnt_r   <= cnt_r + 1'b1;
          state_r <= last_r ? Q_POS : IDLE;
        end
        Q_POS: begin
          pos_r   <= 28'(cnt_r - 1'b1) * 28'(psat);
          state_r <= Q_RDA;
        end
        Q_RDA: begin
          lo_r     <= lo_c;
          need_b_r <= (pos_r[15:0] != '0) &&
                      ((CNT_W'({1'b0, lo_c}) + 1'b1) < cnt_r);
          state_r  <= Q_RDB;
        end
        Q_RDB: begin
          a_r   <= rd_r;
          res_r <= rd_r;
          if (need_b_r && lo_inc < cnt_r) begin
            state_r <= Q_MUL;
          end else begin
            state_r <= Q_EMIT;
          end
        end
        Q_MUL: begin
          prod_r  <= 48'(diff) * 48'(pos_r[15:0]);
          state_r <= Q_EMIT;
          idx_r   <= '0;
          last_r  <= 1'b1;
          res_r   <= '0;
        end
        Q_EMIT: begin
          if (out_free) begin
            out_r.quantile_value       <= (res_r == '0 && last_r && idx_r == '0 && need_b_r)
                                          ? 32'(a_r + 32'(prod_r[47:16]))
                                          : res_r;
            out_r.prob_index           <= qi_r;
            out_r.sample_count         <= cnt_r;
            out_r.overflow             <= ovf_r;
            out_r.last_result          <= q_last;
            need_b_r                   <= 1'b0;
            if (q_last) begin
              cnt_r   <= '0;
              ovf_r   <= 1'b0;
              state_r <= IDLE;
            end else begin
              qi_r    <= qi_r + 1'b1;
              state_r <= Q_POS;
            end
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond capacity");

  a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SHIFT |-> idx_r != '0)
    else $error("shift at store base");

  a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == Q_EMIT && out_free && q_last) |=> (state_r == IDLE && cnt_r == '0))
    else $error("set not cleared after final result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == Q_EMIT && !out_free) |=> state_r == Q_EMIT)
    else $error("result lost while output stalled");

endmodule
